### hw/rtl/mcss_pkg.sv
// Package for the MIDI clock step sequencer: item types, codes and defaults.
`default_nettype none

package mcss_pkg;

  localparam int NOTE_DEPTH_DEF = 16;
  localparam int STEP_DEPTH_DEF = 16;

  localparam int VALUE_W = 7;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'd144;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'd128;

  localparam logic [VALUE_W-1:0] CPU_RESET   = 7'd3;
  localparam logic [VALUE_W-1:0] LEN_MIN     = 7'd1;
  localparam logic [VALUE_W-1:0] LEN_MAX     = 7'd64;

  localparam int TICK_W = 13;
  localparam int SPAN_W = 2 * VALUE_W;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LOAD_NOTE = 2'd1,
    CMD_LOAD_STEP = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] pitch;
    logic [VALUE_W-1:0] velocity;
    logic [VALUE_W-1:0] step_length;
  } item_t;

  typedef struct packed {
    logic [7:0]         status_byte;
    logic [VALUE_W-1:0] note_pitch_out;
    logic [VALUE_W-1:0] note_velocity_out;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/midi_clock_step_sequencer.sv
// Top level of the MIDI clock step sequencer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   item     | item_valid/stall     | item_t: cmd, pitch, velocity, step_length
//   result   | result_valid/stall   | result_t: status, pitch, velocity, last
//   cfg      | cfg_valid/ready      | clocks_per_unit (7 bits)
//
// An item is taken while item_stall is low. A tick that plays a note reads the
// note RAM, then gives note-on and note-off from the result register; a later
// note waits until note-off is taken. Loads and silent ticks go every cycle
// unless stalled. Step lengths fetched on a wrap come out of the length RAM in
// the next cycle. rst is synchronous; the tables are not cleared. Result stall
// backs up into item_stall only while a read note waits for the result register.
`default_nettype none

module midi_clock_step_sequencer
  import mcss_pkg::*;
#(
  parameter int NOTE_DEPTH = NOTE_DEPTH_DEF,
  parameter int STEP_DEPTH = STEP_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire item_t              item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [VALUE_W-1:0] cfg_data
);

  localparam int NCW = $clog2(NOTE_DEPTH + 1);
  localparam int SCW = $clog2(STEP_DEPTH + 1);
  localparam int NAW = NOTE_DEPTH > 1 ? $clog2(NOTE_DEPTH) : 1;
  localparam int SAW = STEP_DEPTH > 1 ? $clog2(STEP_DEPTH) : 1;
  localparam logic [NCW-1:0] NOTE_FULL = NCW'(NOTE_DEPTH);
  localparam logic [SCW-1:0] STEP_FULL = SCW'(STEP_DEPTH);

  // control state
  logic [VALUE_W-1:0] clocks_per_unit;
  logic [NCW-1:0]     note_count, note_count_next;
  logic [NCW-1:0]     note_index, note_index_next;
  logic [SCW-1:0]     length_count, length_count_next;
  logic [SCW-1:0]     length_index, length_index_next;
  logic [VALUE_W-1:0] current_length, current_length_next;
  logic               len_pending, len_pending_next;
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic               play_pending, play_pending_next;
  logic               result_phase;
  logic [VALUE_W-1:0] result_pitch;
  logic [VALUE_W-1:0] result_velocity;

  // RAM ports
  logic                   note_we, note_re;
  logic [NAW-1:0]         note_waddr, note_raddr;
  logic [2*VALUE_W-1:0]   note_rdata;
  logic                   len_we, len_re;
  logic [SAW-1:0]         len_waddr, len_raddr;
  logic [VALUE_W-1:0]     len_wdata, len_rdata;

  logic               accept;
  logic               out_free;
  logic               move;
  logic [VALUE_W-1:0] rate;
  logic [VALUE_W-1:0] len_eff;
  logic [VALUE_W-1:0] len_clamped;
  logic [SPAN_W-1:0]  span;
  logic               tick_wrap;
  logic [NCW-1:0]     note_ptr;
  logic [SCW-1:0]     step_ptr;

  assign cfg_ready = 1'b1;

  assign out_free   = !result_valid || (result_phase && !result_stall);
  assign move       = play_pending && out_free;
  assign item_stall = play_pending && !out_free;
  assign accept     = item_valid && !item_stall;

  assign rate      = (clocks_per_unit == '0) ? LEN_MIN : clocks_per_unit;
  assign len_eff   = len_pending ? len_rdata : current_length;
  assign span      = SPAN_W'(rate) * SPAN_W'(len_eff);
  // tick_count >= span - 1, with span never zero
  assign tick_wrap = (SPAN_W'(tick_count) + SPAN_W'(1)) >= span;

  assign note_ptr = (note_index >= note_count) ? '0 : note_index;
  assign step_ptr = (length_index >= length_count) ? '0 : length_index;

  always_comb begin
    if (item.step_length == '0) begin
      len_clamped = LEN_MIN;
    end else if (item.step_length > LEN_MAX) begin
      len_clamped = LEN_MAX;
    end else begin
      len_clamped = item.step_length;
    end
  end

  always_comb begin
    note_count_next     = note_count;
    note_index_next     = note_index;
    length_count_next   = length_count;
    length_index_next   = length_index;
    current_length_next = len_eff;
    len_pending_next    = 1'b0;
    tick_count_next     = tick_count;
    play_pending_next   = play_pending && !move;
    note_we    = 1'b0;
    note_waddr = note_count[NAW-1:0];
    note_re    = 1'b0;
    note_raddr = note_ptr[NAW-1:0];
    len_we     = 1'b0;
    len_waddr  = length_count[SAW-1:0];
    len_wdata  = len_clamped;
    len_re     = 1'b0;
    len_raddr  = step_ptr[SAW-1:0];
    if (accept) begin
      case (item.cmd)
        CMD_LOAD_NOTE: begin
          if (note_count < NOTE_FULL) begin
            note_we         = 1'b1;
            note_count_next = note_count + NCW'(1);
          end
        end
        CMD_LOAD_STEP: begin
          if (length_count < STEP_FULL) begin
            len_we            = 1'b1;
            length_count_next = length_count + SCW'(1);
            // first step becomes the current length right away
            if (length_count == '0) begin
              current_length_next = len_clamped;
              length_index_next   = SCW'(1);
            end
          end
        end
        CMD_TICK: begin
          if (tick_count == '0 && note_count != '0) begin
            note_re           = 1'b1;
            note_index_next   = note_ptr + NCW'(1);
            play_pending_next = 1'b1;
          end
          if (tick_wrap) begin
            tick_count_next = '0;
            if (length_count != '0) begin
              len_re            = 1'b1;
              length_index_next = step_ptr + SCW'(1);
              len_pending_next  = 1'b1;
            end
          end else begin
            tick_count_next = tick_count + TICK_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clocks_per_unit <= CPU_RESET;
      note_count      <= '0;
      note_index      <= '0;
      length_count    <= '0;
      length_index    <= '0;
      current_length  <= LEN_MIN;
      len_pending     <= 1'b0;
      tick_count      <= '0;
      play_pending    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clocks_per_unit <= cfg_data;
      end
      note_count     <= note_count_next;
      note_index     <= note_index_next;
      length_count   <= length_count_next;
      length_index   <= length_index_next;
      current_length <= current_length_next;
      len_pending    <= len_pending_next;
      tick_count     <= tick_count_next;
      play_pending   <= play_pending_next;
    end
  end

  // result register: note-on, then note-off of the same note
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      result_phase <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
      result_phase <= 1'b0;
    end else if (result_valid && !result_stall) begin
      if (result_phase) begin
        result_valid <= 1'b0;
      end else begin
        result_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_pitch    <= note_rdata[2*VALUE_W-1:VALUE_W];
      result_velocity <= note_rdata[VALUE_W-1:0];
    end
  end

  always_comb begin
    result.status_byte       = result_phase ? STATUS_NOTE_OFF : STATUS_NOTE_ON;
    result.note_pitch_out    = result_pitch;
    result.note_velocity_out = result_velocity;
    result.last              = result_phase;
  end

  mcss_ram #(
    .WIDTH(2 * VALUE_W),
    .DEPTH(NOTE_DEPTH)
  ) u_note_ram (
    .clk  (clk),
    .we   (note_we),
    .waddr(note_waddr),
    .wdata({item.pitch, item.velocity}),
    .re   (note_re),
    .raddr(note_raddr),
    .rdata(note_rdata)
  );

  mcss_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STEP_DEPTH)
  ) u_step_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .re   (len_re),
    .raddr(len_raddr),
    .rdata(len_rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/mcss_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none

module mcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
